// ===== rtl/core/ppfl_pkg.sv =====
// shared types and constants of the per-cpu page free list allocator
package ppfl_pkg;

    localparam int ADDR_W     = 39;
    localparam int PAGE_SHIFT = 12;
    localparam int CPU_ID_W   = 3;
    localparam int CPU_SEL_W  = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ADDR = 2'd1,
        ST_NO_PAGE  = 2'd2
    } t_status;

    typedef enum logic {
        OP_FREE  = 1'b0,
        OP_ALLOC = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_POP_HEAD,
        S_POP_LINK
    } t_state;

    typedef struct packed {
        logic                 found;
        logic [CPU_SEL_W-1:0] cpu;
    } t_pick;

endpackage

// ===== rtl/core/ppfl_ram.sv =====
// generic single-write, single-read ram with registered read data
module ppfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/core/ppfl_pick.sv =====
// list selection: own list first, else highest other nonempty list
module ppfl_pick #(
    parameter int CPUS = 8
) (
    input  logic [CPUS-1:0]              i_nonempty,
    input  logic [ppfl_pkg::CPU_ID_W-1:0] i_cpu_id,
    output ppfl_pkg::t_pick              o_pick
);

    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;

    logic w_cpu_valid;

    assign w_cpu_valid = 32'(i_cpu_id) < 32'(CPUS);

    always_comb begin
        o_pick = '0;
        for (int i = 0; i < CPUS; i++) begin
            if (i_nonempty[i] && (i != int'(i_cpu_id))) begin
                o_pick.found = 1'b1;
                o_pick.cpu   = ppfl_pkg::CPU_SEL_W'(i);
            end
        end
        if (w_cpu_valid && i_nonempty[CW'(i_cpu_id)]) begin
            o_pick.found = 1'b1;
            o_pick.cpu   = ppfl_pkg::CPU_SEL_W'(i_cpu_id);
        end
    end

endmodule

// ===== rtl/core/per_cpu_page_free_list_allocator_unit.sv =====
// top level of the per-cpu page free list allocator
//
// channel   direction  handshake            word
// command   in         start, busy          i_opcode, i_cpu_id, i_page_address
// result    out        o_done (1 cycle)     o_status, o_alloc_address
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// a free reads the head ram, then writes the link and head rams
// an alloc reads the head ram, then the link ram, then writes the head back;
// an alloc with every list empty does not leave the idle state
// the result strobe is registered and comes in the cycle after the last step;
// a new command may be taken in that same cycle
// reset is synchronous; all lists come up empty, link ram is not cleared
module per_cpu_page_free_list_allocator_unit #(
    parameter int CPUS  = 8,
    parameter int PAGES = 32768
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_opcode,
    input  logic [ppfl_pkg::CPU_ID_W-1:0]         i_cpu_id,
    input  logic [ppfl_pkg::ADDR_W-1:0]           i_page_address,
    output logic                                  o_done,
    output logic [1:0]                            o_status,
    output logic [ppfl_pkg::ADDR_W-1:0]           o_alloc_address,
    input  logic                                  i_cfg_we,
    input  logic [ppfl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ppfl_pkg::ADDR_W-1:0]           i_cfg_data
);

    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int PW = $clog2(PAGES);
    localparam int HW = $clog2(PAGES + 1);
    localparam int AW = ppfl_pkg::ADDR_W;
    localparam int IW = AW - ppfl_pkg::PAGE_SHIFT;

    ppfl_pkg::t_state  r_state, n_state;
    ppfl_pkg::t_status r_status;
    ppfl_pkg::t_pick   w_pick;

    logic [CPUS-1:0] r_ne;
    logic [CW-1:0]   r_cpu;
    logic            r_cpu_ok;
    logic [AW-1:0]   r_pa;
    logic [AW-1:0]   r_start;
    logic [AW-1:0]   r_end;
    logic [AW-1:0]   r_base;
    logic            r_done;
    logic [AW-1:0]   r_out_addr;
    logic [AW-1:0]   r_pop_addr;

    logic            w_accept;
    logic            w_is_free;
    logic            w_cpu_valid;
    logic [CW-1:0]   w_head_raddr;
    logic [AW-1:0]   w_cfg_round;
    logic [AW-1:0]   w_diff;
    logic [IW-1:0]   w_idx;
    logic            w_free_ok;
    logic [HW-1:0]   w_page;
    logic [AW-1:0]   w_pop_addr;

    logic            w_head_we;
    logic [HW-1:0]   w_head_wdata;
    logic [HW-1:0]   w_head_rdata;
    logic            w_link_we;
    logic [PW-1:0]   w_link_waddr;
    logic [HW-1:0]   w_link_wdata;
    logic [PW-1:0]   w_link_raddr;
    logic [HW-1:0]   w_link_rdata;

    assign busy        = r_state != ppfl_pkg::S_IDLE;
    assign w_accept    = start && !busy;
    assign w_is_free   = i_opcode == ppfl_pkg::OP_FREE;
    assign w_cpu_valid = 32'(i_cpu_id) < 32'(CPUS);
    assign w_head_raddr = w_is_free ? CW'(i_cpu_id) : CW'(w_pick.cpu);
    assign w_cfg_round = i_cfg_data + AW'(4095);

    // free checks
    assign w_diff    = r_pa - r_base;
    assign w_idx     = w_diff[AW-1:ppfl_pkg::PAGE_SHIFT];
    assign w_free_ok = r_cpu_ok && (r_pa[ppfl_pkg::PAGE_SHIFT-1:0] == '0)
                       && (r_pa >= r_start) && (r_pa < r_end) && (r_pa >= r_base)
                       && (32'(w_idx) < 32'(PAGES));

    // an empty list links to the end marker
    assign w_link_wdata = r_ne[r_cpu] ? w_head_rdata : '0;

    // popped page address
    assign w_page     = w_head_rdata - HW'(1);
    assign w_pop_addr = r_base + (AW'(w_page) << ppfl_pkg::PAGE_SHIFT);

    ppfl_pick #(.CPUS(CPUS)) u_pick (
        .i_nonempty (r_ne),
        .i_cpu_id   (i_cpu_id),
        .o_pick     (w_pick)
    );

    ppfl_ram #(.WIDTH(HW), .DEPTH(CPUS)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_we),
        .i_waddr (r_cpu),
        .i_wdata (w_head_wdata),
        .i_raddr (w_head_raddr),
        .o_rdata (w_head_rdata)
    );

    ppfl_ram #(.WIDTH(HW), .DEPTH(PAGES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_link_raddr),
        .o_rdata (w_link_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppfl_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_is_free) begin
                        n_state = ppfl_pkg::S_FREE;
                    end else if (w_pick.found) begin
                        n_state = ppfl_pkg::S_POP_HEAD;
                    end
                end
            end
            ppfl_pkg::S_FREE:     n_state = ppfl_pkg::S_IDLE;
            ppfl_pkg::S_POP_HEAD: n_state = ppfl_pkg::S_POP_LINK;
            ppfl_pkg::S_POP_LINK: n_state = ppfl_pkg::S_IDLE;
            default:              n_state = ppfl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_head_we    = 1'b0;
        w_head_wdata = w_link_rdata;
        w_link_we    = 1'b0;
        w_link_waddr = w_idx[PW-1:0];
        w_link_raddr = PW'(w_page);
        unique case (r_state)
            ppfl_pkg::S_FREE: begin
                w_head_we    = w_free_ok;
                w_head_wdata = HW'(w_idx[PW-1:0]) + HW'(1);
                w_link_we    = w_free_ok;
            end
            ppfl_pkg::S_POP_LINK: begin
                w_head_we = 1'b1;
            end
            default: begin
                w_head_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppfl_pkg::S_IDLE;
            r_ne    <= '0;
            r_done  <= 1'b0;
            r_start <= '0;
            r_end   <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == ppfl_pkg::REG_REGION_START) begin
                    r_start <= i_cfg_data;
                    r_base  <= {w_cfg_round[AW-1:ppfl_pkg::PAGE_SHIFT],
                                ppfl_pkg::PAGE_SHIFT'(0)};
                end else if (i_cfg_idx == ppfl_pkg::REG_REGION_END) begin
                    r_end <= i_cfg_data;
                end
            end
            unique case (r_state)
                ppfl_pkg::S_IDLE: begin
                    r_done <= w_accept && !w_is_free && !w_pick.found;
                end
                ppfl_pkg::S_FREE: begin
                    r_done <= 1'b1;
                    if (w_free_ok) begin
                        r_ne[r_cpu] <= 1'b1;
                    end
                end
                ppfl_pkg::S_POP_LINK: begin
                    r_done      <= 1'b1;
                    r_ne[r_cpu] <= w_link_rdata != '0;
                end
                default: begin
                    r_done <= 1'b0;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pa     <= i_page_address;
            r_cpu    <= w_head_raddr;
            r_cpu_ok <= w_cpu_valid;
        end
        if (r_state == ppfl_pkg::S_POP_HEAD) begin
            r_pop_addr <= w_pop_addr;
        end
        unique case (r_state)
            ppfl_pkg::S_IDLE: begin
                r_status   <= ppfl_pkg::ST_NO_PAGE;
                r_out_addr <= '0;
            end
            ppfl_pkg::S_FREE: begin
                r_status   <= w_free_ok ? ppfl_pkg::ST_OK : ppfl_pkg::ST_BAD_ADDR;
                r_out_addr <= '0;
            end
            ppfl_pkg::S_POP_LINK: begin
                r_status   <= ppfl_pkg::ST_OK;
                r_out_addr <= r_pop_addr;
            end
            default: begin
                r_status   <= ppfl_pkg::ST_OK;
                r_out_addr <= '0;
            end
        endcase
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_alloc_address = r_out_addr;

endmodule

// ===== tb/per_cpu_page_free_list_allocator_unit_tb.sv =====
// testbench of the per-cpu page free list allocator with a predictor of the lists
module per_cpu_page_free_list_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCPU = 8;
    localparam int NPAGES = 32768;
    localparam int QUIET_LIMIT = 5000;
    localparam logic [38:0] START_A = 39'h00_1000_0123;
    localparam logic [38:0] BASE_A = 39'h00_1000_1000;
    localparam logic [38:0] END_A = 39'h00_1800_3000;
    localparam logic [38:0] ALL_ONES = 39'h7F_FFFF_FFFF;

    typedef struct {
        ppfl_pkg::t_opcode op;
        logic [2:0]        cpu;
        logic [38:0]       pa;
    } t_cmd;

    typedef struct {
        ppfl_pkg::t_status st;
        logic [38:0]       addr;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_opcode = 1'b0;
    logic [ppfl_pkg::CPU_ID_W-1:0] i_cpu_id = '0;
    logic [ppfl_pkg::ADDR_W-1:0] i_page_address = '0;
    logic o_done;
    logic [1:0] o_status;
    logic [ppfl_pkg::ADDR_W-1:0] o_alloc_address;
    logic i_cfg_we = 1'b0;
    logic [ppfl_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ppfl_pkg::ADDR_W-1:0] i_cfg_data = '0;

    t_cmd cmd_q[$];
    t_outcome due_q[$];
    t_cmd nxt;
    t_outcome got_exp;
    bit in_flight = 1'b0;
    int gap_left = 0;
    int calm_left = 0;
    int errors = 0;
    int quiet = 0;

    logic [38:0] region_lo = '0;
    logic [38:0] region_hi = '0;
    logic [15:0] free_heads [NCPU];
    logic [15:0] free_links [NPAGES];

    per_cpu_page_free_list_allocator_unit #(
        .CPUS(NCPU),
        .PAGES(NPAGES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_cpu_id(i_cpu_id),
        .i_page_address(i_page_address),
        .o_done(o_done),
        .o_status(o_status),
        .o_alloc_address(o_alloc_address),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] page_base();
        return ({25'b0, region_lo} + 64'd4095) & ~64'hFFF;
    endfunction

    function automatic logic [63:0] page_count();
        logic [63:0] base;
        logic [63:0] n;
        base = page_base();
        if ({25'b0, region_hi} <= base) return 64'd0;
        n = ({25'b0, region_hi} - base + 64'd4095) >> 12;
        return (n > NPAGES) ? NPAGES : n;
    endfunction

    function automatic bit take_page(int c, output int pg);
        if (free_heads[c] == 16'd0) return 1'b0;
        pg = free_heads[c] - 1;
        free_heads[c] = free_links[pg];
        return 1'b1;
    endfunction

    function automatic void track_word(logic op, logic [2:0] cpu, logic [38:0] pa);
        logic [63:0] base;
        logic [63:0] pa64;
        logic [63:0] idx;
        logic [63:0] sum;
        int pg;
        bit got;
        t_outcome res;
        base = page_base();
        pa64 = {25'b0, pa};
        res.st = ppfl_pkg::ST_OK;
        res.addr = '0;
        pg = 0;
        if (op == ppfl_pkg::OP_FREE) begin
            if (pa[11:0] != 12'b0 || pa < region_lo || pa >= region_hi || pa64 < base) begin
                res.st = ppfl_pkg::ST_BAD_ADDR;
            end else begin
                idx = (pa64 - base) >> 12;
                if (idx >= NPAGES) begin
                    res.st = ppfl_pkg::ST_BAD_ADDR;
                end else begin
                    free_links[idx] = free_heads[cpu];
                    free_heads[cpu] = idx[15:0] + 16'd1;
                end
            end
        end else begin
            got = take_page(cpu, pg);
            // steal scan from the highest cpu down, skipping the requester
            for (int c = NCPU - 1; c >= 0 && !got; c--) begin
                if (c != cpu) got = take_page(c, pg);
            end
            if (!got) begin
                res.st = ppfl_pkg::ST_NO_PAGE;
            end else begin
                sum = base + ({32'b0, pg} << 12);
                res.addr = sum[38:0];
            end
        end
        due_q.push_back(res);
    endfunction

    function automatic logic [38:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[38:0];
    endfunction

    function automatic int next_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    task automatic queue_word(ppfl_pkg::t_opcode op, int cpu, logic [38:0] pa);
        t_cmd w;
        w.op = op;
        w.cpu = cpu[2:0];
        w.pa = pa;
        cmd_q.push_back(w);
    endtask

    task automatic write_reg(logic [ppfl_pkg::CFG_IDX_W-1:0] idx, logic [38:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == ppfl_pkg::REG_REGION_START) region_lo = val;
        else region_hi = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (cmd_q.size() != 0 || in_flight || due_q.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic random_words(int n);
        logic [63:0] base;
        logic [63:0] cnt;
        logic [63:0] k;
        logic [63:0] pa;
        base = page_base();
        cnt = page_count();
        repeat (n) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_word(ppfl_pkg::OP_ALLOC, $urandom_range(0, 7), rand_addr());
            end else begin
                k = (cnt != 0) ? $urandom_range(0, cnt - 1) : 0;
                if (cnt != 0 && $urandom_range(0, 99) < 75) begin
                    pa = base + (k << 12);
                end else begin
                    case ($urandom_range(0, 4))
                        0: pa = base + (k << 12) + $urandom_range(1, 4095);
                        1: pa = base - 64'd4096;
                        2: pa = ({25'b0, region_hi} + 64'd4095) & ~64'hFFF;
                        3: pa = base + NPAGES * 64'd4096;
                        default: pa = {25'b0, rand_addr()};
                    endcase
                end
                queue_word(ppfl_pkg::OP_FREE, $urandom_range(0, 7), pa[38:0]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                track_word(i_opcode, i_cpu_id, i_page_address);
                in_flight = 1'b0;
            end
            if (gap_left != 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (cmd_q.size() != 0) begin
                nxt = cmd_q.pop_front();
                in_flight = 1'b1;
                start <= 1'b1;
                i_opcode <= nxt.op;
                i_cpu_id <= nxt.cpu;
                i_page_address <= nxt.pa;
                gap_left = next_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (due_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual status %0d address %h",
                         $time, o_status, o_alloc_address);
                errors++;
            end else begin
                got_exp = due_q.pop_front();
                if (o_status !== got_exp.st) begin
                    $display("%0t: status: expected %0d, actual %0d",
                             $time, got_exp.st, o_status);
                    errors++;
                end
                if (o_alloc_address !== got_exp.addr) begin
                    $display("%0t: alloc_address: expected %h, actual %h",
                             $time, got_exp.addr, o_alloc_address);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_done)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("per_cpu_page_free_list_allocator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        foreach (free_heads[c]) free_heads[c] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset region is empty
        queue_word(ppfl_pkg::OP_FREE, 0, '0);
        queue_word(ppfl_pkg::OP_ALLOC, 7, ALL_ONES);
        settle();

        write_reg(ppfl_pkg::REG_REGION_START, START_A);
        write_reg(ppfl_pkg::REG_REGION_END, END_A);
        queue_word(ppfl_pkg::OP_FREE, 3, BASE_A);
        queue_word(ppfl_pkg::OP_FREE, 3, BASE_A + 39'h1000);
        queue_word(ppfl_pkg::OP_FREE, 7, BASE_A + (NPAGES - 1) * 39'h1000);
        queue_word(ppfl_pkg::OP_FREE, 0, BASE_A + 39'h1);
        queue_word(ppfl_pkg::OP_FREE, 0, START_A);
        queue_word(ppfl_pkg::OP_FREE, 0, BASE_A - 39'h1000);
        queue_word(ppfl_pkg::OP_FREE, 0, BASE_A + NPAGES * 39'h1000);
        queue_word(ppfl_pkg::OP_FREE, 0, END_A);
        queue_word(ppfl_pkg::OP_FREE, 0, ALL_ONES);
        queue_word(ppfl_pkg::OP_FREE, 5, 39'h7F_FFFF_F000);
        queue_word(ppfl_pkg::OP_ALLOC, 3, '0);
        queue_word(ppfl_pkg::OP_ALLOC, 0, '0);
        queue_word(ppfl_pkg::OP_ALLOC, 7, '0);
        queue_word(ppfl_pkg::OP_ALLOC, 0, '0);
        queue_word(ppfl_pkg::OP_ALLOC, 3, '0);
        // same page freed to two lists
        queue_word(ppfl_pkg::OP_FREE, 1, BASE_A + 39'h5000);
        queue_word(ppfl_pkg::OP_FREE, 2, BASE_A + 39'h5000);
        queue_word(ppfl_pkg::OP_ALLOC, 1, '0);
        queue_word(ppfl_pkg::OP_ALLOC, 2, '0);
        queue_word(ppfl_pkg::OP_ALLOC, 4, '0);
        queue_word(ppfl_pkg::OP_FREE, 0, BASE_A + 39'h2000);
        queue_word(ppfl_pkg::OP_ALLOC, 0, ALL_ONES);
        random_words(200);
        settle();

        write_reg(ppfl_pkg::REG_REGION_START, '0);
        write_reg(ppfl_pkg::REG_REGION_END, ALL_ONES);
        random_words(190);
        settle();

        // base moves while pages are listed
        write_reg(ppfl_pkg::REG_REGION_START, 39'h7F_FFF0_0800);
        random_words(190);
        settle();

        write_reg(ppfl_pkg::REG_REGION_START, ALL_ONES);
        random_words(100);
        settle();

        write_reg(ppfl_pkg::REG_REGION_START, 39'h00_2000_0000);
        write_reg(ppfl_pkg::REG_REGION_END, '0);
        random_words(60);
        settle();

        write_reg(ppfl_pkg::REG_REGION_START, '0);
        write_reg(ppfl_pkg::REG_REGION_END, 39'h00_0008_0000);
        random_words(210);
        settle();

        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("per_cpu_page_free_list_allocator_unit: match");
        end else begin
            $display("per_cpu_page_free_list_allocator_unit: mismatch");
        end
        $finish;
    end
endmodule
